// ===== rtl/core/pcdm_pkg.sv =====
package pcdm_pkg;

  // Field widths
  localparam int CMD_W = 2;
  localparam int CH_W  = 3;
  localparam int VAL_W = 8;

  // Full-scale duty percentage
  localparam logic [VAL_W-1:0] PCT_FULL = 8'd100;

  // Steps of the serial unit: one multiplier or quotient bit per cycle
  localparam int SU_STEPS = VAL_W;
  localparam int SU_CNT_W = $clog2(SU_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT          = 2'd0,
    CMD_DISABLE       = 2'd1,
    CMD_SET_DUTY      = 2'd2,
    CMD_CHANGE_PERIOD = 2'd3
  } pcdm_cmd_t;

  typedef enum logic {
    SU_MUL = 1'b0,
    SU_DIV = 1'b1
  } pcdm_su_op_t;

  // Command request
  typedef struct packed {
    pcdm_cmd_t        command;
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;
  } pcdm_in_t;

  // Result
  typedef struct packed {
    logic [CH_W-1:0]  channel_out;
    logic [VAL_W-1:0] period_out;
    logic [VAL_W-1:0] duty_out;
    logic             enabled_out;
    logic             ignored;
  } pcdm_out_t;

  // One channel's settings
  typedef struct packed {
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] duty;
    logic             en;
  } pcdm_chan_t;

  // Channel bank write
  typedef struct packed {
    logic            we;
    logic [CH_W-1:0] ch;
    pcdm_chan_t      data;
  } pcdm_wr_t;

endpackage

// ===== rtl/core/pcdm_bank.sv =====
module pcdm_bank #(
  parameter int CHANNELS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [pcdm_pkg::CH_W-1:0] rd_ch,
  output pcdm_pkg::pcdm_chan_t     rd_data,
  input  pcdm_pkg::pcdm_wr_t       wr
);
  import pcdm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

  pcdm_chan_t bank_r [CHANNELS];

  // Read port; out-of-range channels read as zero
  always_comb begin
    if ({1'b0, rd_ch} < CH_LIMIT) begin
      rd_data = bank_r[rd_ch[IDX_W-1:0]];
    end else begin
      rd_data = '0;
    end
  end

  // Write port, cleared on reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (!rst_n) begin
        bank_r[i] <= '0;
      end else if (wr.we && (wr.ch == CH_W'(i))) begin
        bank_r[i] <= wr.data;
      end
    end
  end

endmodule

// ===== rtl/core/pcdm_serial_unit.sv =====
module pcdm_serial_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  pcdm_pkg::pcdm_su_op_t       op,
  input  logic [pcdm_pkg::VAL_W-1:0]  opnd,
  input  logic [2*pcdm_pkg::VAL_W-1:0] init,
  output logic                        done,
  output logic [2*pcdm_pkg::VAL_W-1:0] result
);
  import pcdm_pkg::*;

  // Work register: high half is the accumulator / partial remainder,
  // low half the multiplier bits / dividend bits turning into quotient.
  logic [2*VAL_W-1:0] work_r, work_nxt;
  logic [VAL_W-1:0]   opnd_r;
  pcdm_su_op_t        op_r;
  logic               run_r;
  logic               done_r;
  logic [SU_CNT_W-1:0] cnt_r;

  logic [VAL_W:0]     mul_sum;
  logic [VAL_W:0]     div_trial;
  logic [VAL_W:0]     div_diff;
  logic               div_ge;
  logic [VAL_W-1:0]   div_rem;

  // One shift-add or one restoring-divide step per cycle
  always_comb begin
    mul_sum   = {1'b0, work_r[2*VAL_W-1:VAL_W]} +
                (work_r[0] ? {1'b0, opnd_r} : {(VAL_W+1){1'b0}});
    div_trial = {work_r[2*VAL_W-1:VAL_W], work_r[VAL_W-1]};
    div_diff  = div_trial - {1'b0, opnd_r};
    div_ge    = (div_trial >= {1'b0, opnd_r});
    div_rem   = div_ge ? div_diff[VAL_W-1:0] : div_trial[VAL_W-1:0];
    case (op_r)
      SU_MUL:  work_nxt = {mul_sum, work_r[VAL_W-1:1]};
      default: work_nxt = {div_rem, work_r[VAL_W-2:0], div_ge};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SU_CNT_W'(SU_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk) begin
    if (go) begin
      work_r <= init;
      opnd_r <= opnd;
      op_r   <= op;
    end else if (run_r) begin
      work_r <= work_nxt;
    end
  end

  assign done   = done_r;
  assign result = work_r;

endmodule

// ===== rtl/core/pwm_channel_duty_manager_top.sv =====
// Sequence: dispatch finishes init, disable, an out-of-range channel or a change
//   period on a zero period; set duty makes two and change period four 8-step
//   passes through the bit-serial mul/div unit before the registered result strobe.
// Throughput: busy stays high until the strobe cycle, so the next request is
//   taken at the edge that takes the result; the receiver cannot stall.
// Reset (sync, active low): all channels cleared to period 0, duty 0, disabled.
module pwm_channel_duty_manager_top #(
  parameter int CHANNELS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pcdm_pkg::pcdm_in_t  in_req,
  output logic                out_valid,
  output pcdm_pkg::pcdm_out_t out_res
);
  import pcdm_pkg::*;

  localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_MUL1,
    S_DIV1,
    S_MUL2,
    S_DIV2
  } state_t;

  state_t     state_r, state_nxt;
  pcdm_in_t   req_r, req_nxt;
  logic       out_valid_r, out_valid_nxt;
  pcdm_out_t  out_res_r, out_res_nxt;

  pcdm_chan_t rd_data;
  pcdm_chan_t new_chan;
  pcdm_wr_t   wr;
  logic       ch_ok;
  logic       fin;
  logic [VAL_W-1:0] pct_sat;

  logic                 su_go;
  pcdm_su_op_t          su_op;
  logic [VAL_W-1:0]     su_opnd;
  logic [2*VAL_W-1:0]   su_init;
  logic                 su_done;
  logic [2*VAL_W-1:0]   su_res;

  pcdm_bank #(
    .CHANNELS (CHANNELS)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_ch   (req_r.channel),
    .rd_data (rd_data),
    .wr      (wr)
  );

  pcdm_serial_unit u_su (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (su_go),
    .op     (su_op),
    .opnd   (su_opnd),
    .init   (su_init),
    .done   (su_done),
    .result (su_res)
  );

  assign ch_ok   = ({1'b0, req_r.channel} < CH_LIMIT);
  assign pct_sat = (req_r.value > PCT_FULL) ? PCT_FULL : req_r.value;

  // Command sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    su_go         = 1'b0;
    su_op         = SU_MUL;
    su_opnd       = '0;
    su_init       = '0;
    fin           = 1'b0;
    new_chan      = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (!ch_ok) begin
          fin = 1'b1;
        end else begin
          unique case (req_r.command)
            CMD_INIT: begin
              new_chan.period = req_r.value;
              new_chan.duty   = '0;
              new_chan.en     = 1'b1;
              fin             = 1'b1;
            end
            CMD_DISABLE: begin
              new_chan.en = 1'b0;
              fin         = 1'b1;
            end
            CMD_SET_DUTY: begin
              // period * pct
              su_go     = 1'b1;
              su_op     = SU_MUL;
              su_opnd   = rd_data.period;
              su_init   = {{VAL_W{1'b0}}, pct_sat};
              state_nxt = S_MUL1;
            end
            CMD_CHANGE_PERIOD: begin
              if (rd_data.period == '0) begin
                new_chan.period = req_r.value;
                new_chan.duty   = '0;
                fin             = 1'b1;
              end else begin
                // duty * 100
                su_go     = 1'b1;
                su_op     = SU_MUL;
                su_opnd   = rd_data.duty;
                su_init   = {{VAL_W{1'b0}}, PCT_FULL};
                state_nxt = S_MUL1;
              end
            end
          endcase
        end
      end
      S_MUL1: begin
        if (su_done) begin
          su_go     = 1'b1;
          su_op     = SU_DIV;
          su_opnd   = (req_r.command == CMD_SET_DUTY) ? PCT_FULL : rd_data.period;
          su_init   = su_res;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (su_done) begin
          if (req_r.command == CMD_SET_DUTY) begin
            new_chan.duty = su_res[VAL_W-1:0];
            fin           = 1'b1;
          end else begin
            // kept percentage times new period
            su_go     = 1'b1;
            su_op     = SU_MUL;
            su_opnd   = su_res[VAL_W-1:0];
            su_init   = {{VAL_W{1'b0}}, req_r.value};
            state_nxt = S_MUL2;
          end
        end
      end
      S_MUL2: begin
        if (su_done) begin
          su_go     = 1'b1;
          su_op     = SU_DIV;
          su_opnd   = PCT_FULL;
          su_init   = su_res;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (su_done) begin
          new_chan.duty   = su_res[VAL_W-1:0];
          new_chan.period = req_r.value;
          fin             = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Finish: write back and present the result
    if (fin) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      out_res_nxt.channel_out = req_r.channel;
      if (ch_ok) begin
        out_res_nxt.period_out  = new_chan.period;
        out_res_nxt.duty_out    = new_chan.duty;
        out_res_nxt.enabled_out = new_chan.en;
        out_res_nxt.ignored     = 1'b0;
      end else begin
        out_res_nxt.period_out  = '0;
        out_res_nxt.duty_out    = '0;
        out_res_nxt.enabled_out = 1'b0;
        out_res_nxt.ignored     = 1'b1;
      end
    end
  end

  // Bank write: enable, channel, new settings
  assign wr = {fin && ch_ok, req_r.channel, new_chan};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r     <= req_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
